[rtl/rfpfd_pkg.sv]
// ----------------------------------------------------------------------------
// rfpfd_pkg
// Types and constants shared by the remote pulse frame decoder modules.
// ----------------------------------------------------------------------------
package rfpfd_pkg;

  localparam int TIMING_W = 16;
  localparam int SYNC_W   = 11;
  localparam int CODE_W   = 24;
  localparam int CHAN_N   = 5;

  // Index of the last timing of a well-formed frame (sync plus 48 data).
  localparam logic [5:0] LAST_IDX  = 6'd48;
  localparam logic [5:0] COUNT_MAX = 6'd63;

  // Button patterns, code bits 10 to 19 in arrival order.
  localparam logic [9:0] BTN_A_CODE = 10'b0001010101;
  localparam logic [9:0] BTN_B_CODE = 10'b0100010101;
  localparam logic [9:0] BTN_C_CODE = 10'b0101000101;
  localparam logic [9:0] BTN_D_CODE = 10'b0101010001;
  localparam logic [9:0] BTN_E_CODE = 10'b0101010100;

  localparam logic [3:0] PWR_ON_CODE  = 4'b0001;
  localparam logic [3:0] PWR_OFF_CODE = 4'b0100;

  typedef enum logic [1:0] {
    CFG_PULSE_THRESHOLD = 2'd0,
    CFG_SYNC_DELAY_LOW  = 2'd1,
    CFG_SYNC_DELAY_HIGH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_BAD_LENGTH  = 3'd1,
    STATUS_BAD_SYNC    = 3'd2,
    STATUS_BAD_PAIR    = 3'd3,
    STATUS_BAD_CHANNEL = 3'd4,
    STATUS_BAD_BUTTON  = 3'd5,
    STATUS_BAD_POWER   = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    BUTTON_A = 3'd0,
    BUTTON_B = 3'd1,
    BUTTON_C = 3'd2,
    BUTTON_D = 3'd3,
    BUTTON_E = 3'd4
  } button_e;

  // Role of one timing within the frame.
  typedef enum logic [1:0] {
    TOK_SYNC   = 2'd0,
    TOK_FIRST  = 2'd1,
    TOK_SECOND = 2'd2,
    TOK_SKIP   = 2'd3
  } tok_kind_e;

  typedef struct packed {
    logic [TIMING_W-1:0] pulse_us;
    logic                frame_end;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [CHAN_N-1:0] channel_bits;
    logic [2:0]        button;
    logic              power_on;
  } out_item_t;

  typedef struct packed {
    logic [TIMING_W-1:0] pulse_threshold;
    logic [SYNC_W-1:0]   sync_delay_low;
    logic [SYNC_W-1:0]   sync_delay_high;
  } cfg_t;

  // Classified timing handed from the front end to the back end.
  typedef struct packed {
    tok_kind_e kind;
    logic      is_long;
    logic      sync_ok;
    logic      last;
    logic      len_ok;
  } tok_t;

endpackage

[rtl/rf_remote_pulse_frame_decoder.sv]
// ----------------------------------------------------------------------------
// rf_remote_pulse_frame_decoder
// Decoder for pulse timing frames of a fixed-code 433 MHz remote.
// ----------------------------------------------------------------------------
// The block takes one pulse or gap timing per transfer, with frame_end set on
// the last timing of a captured frame, and returns one result per frame. A
// valid frame is a sync timing followed by 48 data timings; the sync passes
// when timing / 31 lies strictly between sync_delay_low and sync_delay_high,
// and each pair of data timings gives one code bit by comparing it against
// pulse_threshold. The 24 code bits are split into five channel switches, a
// button pattern (A to E) and a power code. The status field reports the
// first problem found (length first, then sync or pair errors in arrival
// order, then channel, button and power); on any error the other result
// fields read zero. One timing is accepted every clock cycle while full is
// low: the front end counts and classifies each timing as it is accepted and
// hands it through a short queue to the back end, which shifts in code bits
// and decodes the frame on its last timing, also one timing a cycle unless
// the output queue is full on a last timing. Each result is registered in the
// output queue before it can be popped, where results wait; input transfers
// continue while it holds results, and full rises only when both queues back
// up. Configuration must be written only while no frame is in flight.
// ----------------------------------------------------------------------------
module rf_remote_pulse_frame_decoder import rfpfd_pkg::*; #(
  parameter int TIMING_BITS = 16,
  parameter int MID_DEPTH   = 2,
  parameter int OUT_DEPTH   = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Timing input, queue style.
  input  logic              push,
  output logic              full,
  input  in_item_t          in_item_i,
  // Result output, queue style.
  output logic              empty,
  input  logic              pop,
  output out_item_t         out_item_o,
  // Configuration writes.
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [TIMING_W-1:0] cfg_wdata_i
);

  cfg_t      cfg_q, cfg_d;
  logic      in_accept;
  tok_t      front_tok, back_tok;
  logic      mid_full, mid_empty, tok_pop;
  logic      res_push, res_full;
  out_item_t res_item;

  // Configuration registers; an index beyond the list is ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_PULSE_THRESHOLD: cfg_d.pulse_threshold = cfg_wdata_i;
        CFG_SYNC_DELAY_LOW:  cfg_d.sync_delay_low  = cfg_wdata_i[SYNC_W-1:0];
        CFG_SYNC_DELAY_HIGH: cfg_d.sync_delay_high = cfg_wdata_i[SYNC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pulse_threshold <= TIMING_W'(700);
      cfg_q.sync_delay_low  <= SYNC_W'(300);
      cfg_q.sync_delay_high <= SYNC_W'(400);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full      = mid_full;
  assign in_accept = push && !mid_full;

  rfpfd_front #(
    .TIMING_BITS(TIMING_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_accept),
    .in_item_i  (in_item_i),
    .cfg_i      (cfg_q),
    .tok_o      (front_tok)
  );

  // Classified timings between the front and back ends.
  rfpfd_fifo #(
    .WIDTH($bits(tok_t)),
    .DEPTH(MID_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_accept),
    .wdata_i (front_tok),
    .full_o  (mid_full),
    .pop_i   (tok_pop),
    .rdata_o (back_tok),
    .empty_o (mid_empty)
  );

  rfpfd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (!mid_empty),
    .tok_i       (back_tok),
    .tok_pop_o   (tok_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res_item)
  );

  // Finished results wait here until they are popped.
  rfpfd_fifo #(
    .WIDTH($bits(out_item_t)),
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_item),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

endmodule

[rtl/rfpfd_fifo.sv]
// ----------------------------------------------------------------------------
// rfpfd_fifo
// Small synchronous first-in first-out queue with a registered store.
// ----------------------------------------------------------------------------
module rfpfd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

[rtl/rfpfd_front.sv]
// ----------------------------------------------------------------------------
// rfpfd_front
// Counts timings within a frame and classifies each one against the
// configured thresholds.
// ----------------------------------------------------------------------------
module rfpfd_front import rfpfd_pkg::*; #(
  parameter int TIMING_BITS = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  output tok_t     tok_o
);

  logic [5:0]          count_q, count_d;
  logic [TIMING_W-1:0] t_sat;
  logic [SYNC_W:0]     low_plus1;
  logic [TIMING_W:0]   sync_lo_bound, sync_hi_bound, t_ext;

  // Saturate the timing to the configured timing width.
  if (TIMING_BITS < TIMING_W) begin : g_sat
    localparam logic [TIMING_W-1:0] TMax = TIMING_W'((32'd1 << TIMING_BITS) - 1);
    assign t_sat = ((in_item_i.pulse_us >> TIMING_BITS) != '0) ? TMax
                                                              : in_item_i.pulse_us;
  end else begin : g_nosat
    assign t_sat = in_item_i.pulse_us;
  end

  // timing / 31 > low  <=>  timing >= 31 * (low + 1)
  // timing / 31 < high <=>  timing <  31 * high
  assign low_plus1     = {1'b0, cfg_i.sync_delay_low} + 1'b1;
  assign sync_lo_bound = {low_plus1, 5'b0} - (TIMING_W + 1)'(low_plus1);
  assign sync_hi_bound = {1'b0, cfg_i.sync_delay_high, 5'b0}
                         - (TIMING_W + 1)'(cfg_i.sync_delay_high);
  assign t_ext         = {1'b0, t_sat};

  always_comb begin
    tok_o.last    = in_item_i.frame_end;
    tok_o.len_ok  = (count_q == LAST_IDX);
    tok_o.sync_ok = (t_ext >= sync_lo_bound) && (t_ext < sync_hi_bound);
    if (count_q == '0) begin
      tok_o.kind    = TOK_SYNC;
      tok_o.is_long = 1'b0;
    end else if (count_q > LAST_IDX) begin
      tok_o.kind    = TOK_SKIP;
      tok_o.is_long = 1'b0;
    end else if (count_q[0]) begin
      tok_o.kind    = TOK_FIRST;
      tok_o.is_long = (t_sat > cfg_i.pulse_threshold);
    end else begin
      tok_o.kind    = TOK_SECOND;
      tok_o.is_long = (t_sat >= cfg_i.pulse_threshold);
    end
  end

  always_comb begin
    count_d = count_q;
    if (in_valid_i) begin
      if (in_item_i.frame_end) begin
        count_d = '0;
      end else if (count_q != COUNT_MAX) begin
        count_d = count_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

[rtl/rfpfd_back.sv]
// ----------------------------------------------------------------------------
// rfpfd_back
// Assembles the code bits of a frame from classified timings and decodes
// the frame into one result on its last timing.
// ----------------------------------------------------------------------------
module rfpfd_back import rfpfd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      tok_valid_i,
  input  tok_t      tok_i,
  output logic      tok_pop_o,
  input  logic      res_full_i,
  output logic      res_push_o,
  output out_item_t res_o
);

  logic [CODE_W-1:0] code_q, code_d;
  logic              first_long_q, first_long_d;
  status_e           err_q, err_d;
  logic              take;
  logic [9:0]        btn_code;
  logic [3:0]        pwr_code;
  logic [CHAN_N-1:0] chan_hi, chan_on;
  status_e           status;
  button_e           button;
  logic              power_on;

  // A frame's last timing needs room in the result queue.
  assign take       = tok_valid_i && (!tok_i.last || !res_full_i);
  assign tok_pop_o  = take;
  assign res_push_o = take && tok_i.last;

  // Frame state after this timing.
  always_comb begin
    code_d       = code_q;
    first_long_d = first_long_q;
    err_d        = err_q;
    unique case (tok_i.kind)
      TOK_SYNC: begin
        if (!tok_i.sync_ok && err_q == STATUS_OK) begin
          err_d = STATUS_BAD_SYNC;
        end
      end
      TOK_FIRST: begin
        first_long_d = tok_i.is_long;
      end
      TOK_SECOND: begin
        if (first_long_q == tok_i.is_long && err_q == STATUS_OK) begin
          err_d = STATUS_BAD_PAIR;
        end
        code_d = {code_q[CODE_W-2:0], first_long_q && !tok_i.is_long};
      end
      default: begin
      end
    endcase
  end

  // Decode of the completed code; the earliest bit sits at the top.
  always_comb begin
    for (int i = 0; i < CHAN_N; i++) begin
      chan_hi[i] = code_d[CODE_W-1-2*i];
      chan_on[i] = !code_d[CODE_W-2-2*i];
    end
    btn_code = code_d[13:4];
    pwr_code = code_d[3:0];
    button   = BUTTON_A;
    power_on = 1'b0;
    if (!tok_i.len_ok) begin
      status = STATUS_BAD_LENGTH;
    end else if (err_d != STATUS_OK) begin
      status = err_d;
    end else if (chan_hi != '0) begin
      status = STATUS_BAD_CHANNEL;
    end else begin
      status = STATUS_OK;
      priority if (btn_code == BTN_A_CODE) button = BUTTON_A;
      else if (btn_code == BTN_B_CODE) button = BUTTON_B;
      else if (btn_code == BTN_C_CODE) button = BUTTON_C;
      else if (btn_code == BTN_D_CODE) button = BUTTON_D;
      else if (btn_code == BTN_E_CODE) button = BUTTON_E;
      else status = STATUS_BAD_BUTTON;
      if (status == STATUS_OK) begin
        if (pwr_code == PWR_ON_CODE) begin
          power_on = 1'b1;
        end else if (pwr_code != PWR_OFF_CODE) begin
          status = STATUS_BAD_POWER;
        end
      end
    end
    res_o.status = status;
    if (status == STATUS_OK) begin
      res_o.channel_bits = chan_on;
      res_o.button       = button;
      res_o.power_on     = power_on;
    end else begin
      res_o.channel_bits = '0;
      res_o.button       = BUTTON_A;
      res_o.power_on     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      code_q       <= '0;
      first_long_q <= 1'b0;
      err_q        <= STATUS_OK;
    end else if (take) begin
      if (tok_i.last) begin
        code_q       <= '0;
        first_long_q <= 1'b0;
        err_q        <= STATUS_OK;
      end else begin
        code_q       <= code_d;
        first_long_q <= first_long_d;
        err_q        <= err_d;
      end
    end
  end

endmodule
